>>> hw/rtl/lpm_pkg.sv
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int MAX_PATTERN  = 32;
    localparam int COUNT_BITS   = 32;
    localparam int PATTERN_REGS = 4;
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_SLOTS    = 2 ** PIDX_W;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    localparam logic [31:0] COUNT_LIMIT =
        (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_BITS) - 64'd1);

    // result queue depth, power of two
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [2:0] {
        REG_LENGTH      = 3'd0,
        REG_PAT_LOW     = 3'd1,
        REG_PAT_SECOND  = 3'd2,
        REG_PAT_THIRD   = 3'd3,
        REG_PAT_HIGH    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } cell_data_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] line_number;
        logic [31:0] match_count;
        logic        done;
    } result_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 32'd1;
    endfunction

endpackage

>>> hw/rtl/lpm_cell.sv
`timescale 1ns / 1ps

module lpm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpm_pkg::cell_ctrl_t ctrl,
    input  lpm_pkg::cell_data_t from_prev,
    input  logic               active,
    input  logic [7:0]         pat_byte,
    output lpm_pkg::cell_data_t to_next,
    output logic               eq
);
    import lpm_pkg::*;

    cell_data_t slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
            slot_reg.data  <= '0;
        end else if (ctrl.clear) begin
            slot_reg.valid <= 1'b0;
        end else if (ctrl.shift) begin
            slot_reg <= from_prev;
        end
    end

    // compare on the contents this cell takes in this cycle
    assign eq      = !active || (from_prev.valid && (from_prev.data == pat_byte));
    assign to_next = slot_reg;

endmodule

>>> hw/rtl/lpm_result_fifo.sv
`timescale 1ns / 1ps

module lpm_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  lpm_pkg::result_t entry0,
    input  lpm_pkg::result_t entry1,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output lpm_pkg::result_t head
);
    import lpm_pkg::*;

    result_t               entries [RES_DEPTH];
    logic [RES_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  pop;

    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign room    = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign head    = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        cnt_next    = cnt_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entries[wr_ptr_reg] <= entry0;
        end
        if (push_cnt == 2'd2) begin
            entries[wr_ptr_reg + RES_PTR_W'(1)] <= entry1;
        end
    end

endmodule

>>> hw/rtl/line_pattern_matcher.sv
`timescale 1ns / 1ps

// Fixed-string line search. Text enters one byte per transaction on the s_ channel, with
// s_last_byte on the final byte; every line holding the pattern (registers at APB offsets
// 0x00 length, 0x08..0x20 pattern bytes, lowest byte first) gives one m_ transaction with
// its line number and the running match count, and the final byte adds a done transaction
// carrying the total. A byte is taken every cycle: the window is a row of 32 shift cells,
// each comparing its byte against the aligned pattern byte in the cycle the byte arrives,
// so the match is decided in that cycle. Results pass through a four-entry queue;
// input is held off only while fewer than two entries are free, so sustained throughput
// is one byte per cycle unless the result side stalls. Counts saturate at 2^32 - 1.
module line_pattern_matcher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_line_number,
    output logic [31:0] m_match_count,
    output logic        m_done_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lpm_pkg::*;

    logic [5:0]        len_reg;
    logic [63:0]       pattern_reg [PATTERN_REGS];
    logic [LEN_W-1:0]  len_eff;
    logic [7:0]        pat_bytes [PAT_SLOTS];
    cfg_reg_t          reg_sel;

    logic [31:0]       cur_line_reg, cur_line_next;
    logic [31:0]       matches_reg, matches_next;
    logic              line_matched_reg, line_matched_next;

    cell_data_t        chain [MAX_PATTERN+1];
    cell_ctrl_t        cell_ctrl;
    logic [MAX_PATTERN-1:0] cell_eq;
    logic [MAX_PATTERN-1:0] cell_active;

    logic              accept, is_nl, take_byte, end_line, hit, matched, report;
    logic [31:0]       match_new;
    logic [1:0]        push_cnt;
    result_t           entry0, entry1, head;
    logic              room;

    // configuration
    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            for (int i = 0; i < PATTERN_REGS; i++) begin
                pattern_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_LENGTH:     len_reg        <= pwdata[5:0];
                REG_PAT_LOW:    pattern_reg[0] <= pwdata;
                REG_PAT_SECOND: pattern_reg[1] <= pwdata;
                REG_PAT_THIRD:  pattern_reg[2] <= pwdata;
                REG_PAT_HIGH:   pattern_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LENGTH:     prdata = {58'd0, len_reg};
            REG_PAT_LOW:    prdata = pattern_reg[0];
            REG_PAT_SECOND: prdata = pattern_reg[1];
            REG_PAT_THIRD:  prdata = pattern_reg[2];
            REG_PAT_HIGH:   prdata = pattern_reg[3];
            default:        prdata = '0;
        endcase
    end

    assign len_eff = (len_reg > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_reg);

    // bytes beyond the register set read as zero
    genvar p;
    generate
        for (p = 0; p < PAT_SLOTS; p++) begin : g_pat
            if (p < PATTERN_REGS * 8) begin : g_reg
                assign pat_bytes[p] = pattern_reg[p / 8][(p % 8) * 8 +: 8];
            end else begin : g_zero
                assign pat_bytes[p] = 8'd0;
            end
        end
    endgenerate

    // window cells; cell k holds the byte k places back
    assign chain[0].data  = s_text_byte;
    assign chain[0].valid = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic [LEN_W-1:0] sel;
            assign cell_active[k] = (len_eff > LEN_W'(k));
            assign sel            = len_eff - LEN_W'(k) - LEN_W'(1);

            lpm_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cell_ctrl),
                .from_prev (chain[k]),
                .active    (cell_active[k]),
                .pat_byte  (pat_bytes[sel[PIDX_W-1:0]]),
                .to_next   (chain[k+1]),
                .eq        (cell_eq[k])
            );
        end
    endgenerate

    // transaction handling
    always_comb begin
        accept    = s_valid && s_ready;
        is_nl     = (s_text_byte == NEWLINE_BYTE);
        take_byte = accept && (s_last_byte || !is_nl);
        end_line  = accept && (s_last_byte || is_nl);
        hit       = take_byte && (len_eff != '0) && (&cell_eq);
        matched   = line_matched_reg || hit || (len_eff == '0);
        report    = end_line && matched;
        match_new = report ? sat_inc(matches_reg) : matches_reg;

        cell_ctrl.shift = take_byte;
        cell_ctrl.clear = end_line;

        entry0 = '{line_number: cur_line_reg, match_count: match_new, done: 1'b0};
        entry1 = '{line_number: 32'd0, match_count: match_new, done: 1'b1};
        push_cnt = 2'd0;
        if (accept && s_last_byte) begin
            if (report) begin
                push_cnt = 2'd2;
            end else begin
                push_cnt = 2'd1;
                entry0   = entry1;
            end
        end else if (report) begin
            push_cnt = 2'd1;
        end

        line_matched_next = end_line ? 1'b0 : (line_matched_reg || hit);
        if (accept && s_last_byte) begin
            cur_line_next = 32'd1;
            matches_next  = 32'd0;
        end else begin
            cur_line_next = end_line ? sat_inc(cur_line_reg) : cur_line_reg;
            matches_next  = match_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_line_reg     <= 32'd1;
            matches_reg      <= 32'd0;
            line_matched_reg <= 1'b0;
        end else begin
            cur_line_reg     <= cur_line_next;
            matches_reg      <= matches_next;
            line_matched_reg <= line_matched_next;
        end
    end

    lpm_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .entry0   (entry0),
        .entry1   (entry1),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .head     (head)
    );

    assign s_ready       = room;
    assign m_line_number = head.line_number;
    assign m_match_count = head.match_count;
    assign m_done_res    = head.done;

endmodule

>>> hw/rtl/lpm_checker.sv
`timescale 1ns / 1ps

module lpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_line_number,
    input logic [31:0] m_match_count,
    input logic        m_done_res
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_number)
            && $stable(m_match_count) && $stable(m_done_res))
        else $error("result changed while stalled");

    a_done_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_line_number == 32'd0)
        else $error("done transaction with a line number");

    a_report_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_match_count != 32'd0 && m_line_number != 32'd0)
        else $error("line report with zero count or line");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind line_pattern_matcher lpm_checker u_lpm_checker (.*);

>>> bench/line_pattern_matcher_tb.sv
`timescale 1ns / 1ps

module line_pattern_matcher_tb;

    import lpm_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_line_number;
    logic [31:0] m_match_count;
    logic        m_done_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    line_pattern_matcher i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_number (m_line_number),
        .m_match_count (m_match_count),
        .m_done_res    (m_done_res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // stimulus and expectations
    text_item_t  pending_bytes[$];
    result_t     expected_reports[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned mismatches     = 0;
    logic        byte_taken     = 1'b0;
    logic        no_idle        = 1'b0;

    // matcher shadow state
    logic [5:0]  pattern_length_cfg = '0;
    logic [63:0] pattern_words[PATTERN_REGS];
    logic [7:0]  window_shadow[MAX_PATTERN];
    int unsigned line_fill      = 0;
    logic [31:0] line_index     = 32'd1;
    logic        line_hit       = 1'b0;
    logic [31:0] total_matches  = '0;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (v >= COUNT_LIMIT) ? COUNT_LIMIT : v + 32'd1;
    endfunction

    function automatic int unsigned active_length();
        return (pattern_length_cfg > MAX_PATTERN) ? MAX_PATTERN : pattern_length_cfg;
    endfunction

    function automatic logic [7:0] wanted_byte(input int unsigned k);
        return pattern_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    task automatic clear_line_state();
        for (int i = 0; i < MAX_PATTERN; i++) begin
            window_shadow[i] = 8'h00;
        end
        line_fill = 0;
        line_hit  = 1'b0;
    endtask

    task automatic shift_text_byte(input logic [7:0] b);
        int unsigned len;
        logic        hit;
        len = active_length();
        for (int i = MAX_PATTERN - 1; i > 0; i--) begin
            window_shadow[i] = window_shadow[i - 1];
        end
        window_shadow[0] = b;
        if (line_fill < MAX_PATTERN) begin
            line_fill++;
        end
        if (len != 0 && line_fill >= len) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
                if (window_shadow[len - 1 - j] != wanted_byte(j)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                line_hit = 1'b1;
            end
        end
    endtask

    task automatic close_line();
        result_t r;
        if (line_hit || active_length() == 0) begin
            total_matches     = count_up(total_matches);
            r.line_number     = line_index;
            r.match_count     = total_matches;
            r.done            = 1'b0;
            expected_reports.push_back(r);
        end
        line_index = count_up(line_index);
        clear_line_state();
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        result_t r;
        if (!last && b == NEWLINE_BYTE) begin
            close_line();
        end else begin
            shift_text_byte(b);
            if (last) begin
                close_line();
                r.line_number = '0;
                r.match_count = total_matches;
                r.done        = 1'b1;
                expected_reports.push_back(r);
                clear_line_state();
                line_index    = 32'd1;
                total_matches = '0;
            end
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        text_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (pending_bytes.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
                item = pending_bytes.pop_front();
                s_valid     <= 1'b1;
                s_text_byte <= item.ch;
                s_last_byte <= item.is_last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && (no_idle || $urandom_range(99) >= 28);
    end

    // monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        result_t want;
        byte_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                scan_byte(s_text_byte, s_last_byte);
                bytes_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: line_number %0d match_count %0d done_res %0b",
                           m_line_number, m_match_count, m_done_res);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_line_number !== want.line_number) begin
                        $error("line_number: expected %0d, got %0d",
                               want.line_number, m_line_number);
                        mismatches++;
                    end
                    if (m_match_count !== want.match_count) begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, m_match_count);
                        mismatches++;
                    end
                    if (m_done_res !== want.done) begin
                        $error("done_res: expected %0b, got %0b", want.done, m_done_res);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (idx == REG_LENGTH) begin
            pattern_length_cfg = value[5:0];
        end else begin
            pattern_words[int'(idx) - 1] = value;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        text_item_t item;
        item.ch      = b;
        item.is_last = last;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // hold until every byte is in and every result is out, then let the pipe drain
    task automatic wait_quiet();
        while (bytes_accepted != bytes_queued || expected_reports.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(9);
        if (r <= 6) begin
            return 8'd97 + 8'($urandom_range(2));
        end else if (r == 7) begin
            return 8'h00;
        end else if (r == 8) begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    initial begin
        logic [7:0]  pat[MAX_PATTERN];
        logic [63:0] words[PATTERN_REGS];
        logic [7:0]  line_buf[$];
        logic [5:0]  len_sel;
        int unsigned eff;
        int unsigned random_items;
        int unsigned phase_target;
        int unsigned phase_count;
        int unsigned line_len;
        int unsigned pos;
        int unsigned phase_no;
        logic        embed;
        logic        text_open;
        logic        ends_text;
        logic        mark_last;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = 8'h00;
        s_last_byte = 1'b0;
        m_ready     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        for (int i = 0; i < PATTERN_REGS; i++) begin
            pattern_words[i] = '0;
        end
        clear_line_state();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // length 0 after reset: every line matches, zero byte is plain text
        queue_byte(8'h71, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(NEWLINE_BYTE, 1'b1);
        wait_quiet();

        // short pattern: hit, partial, empty line, hit on the last byte
        write_reg(REG_LENGTH, 64'd3);
        write_reg(REG_PAT_LOW, 64'h0000_0000_0063_6261);
        write_reg(REG_PAT_SECOND, 64'h0);
        write_reg(REG_PAT_THIRD, 64'h0);
        write_reg(REG_PAT_HIGH, 64'h0);
        queue_byte(8'h78, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b1);
        wait_quiet();

        // one-byte pattern of all ones; a final newline is text, not a match
        write_reg(REG_LENGTH, 64'd1);
        write_reg(REG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_byte(8'hFF, 1'b1);
        queue_byte(NEWLINE_BYTE, 1'b1);
        wait_quiet();

        random_items = 0;
        phase_no     = 0;
        text_open    = 1'b0;
        while (random_items < 1150) begin
            case ($urandom_range(9))
                0:       len_sel = 6'd0;
                1:       len_sel = 6'd32;
                2:       len_sel = 6'($urandom_range(63, 33));
                default: len_sel = 6'($urandom_range(6, 1));
            endcase
            eff = (len_sel > MAX_PATTERN) ? MAX_PATTERN : len_sel;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                pat[k] = ($urandom_range(7) == 0) ? 8'hFF : pick_char();
            end
            for (int k = 0; k < MAX_PATTERN; k++) begin
                words[k / 8][(k % 8) * 8 +: 8] = pat[k];
            end
            write_reg(REG_LENGTH, {58'd0, len_sel});
            write_reg(REG_PAT_LOW, words[0]);
            write_reg(REG_PAT_SECOND, words[1]);
            write_reg(REG_PAT_THIRD, words[2]);
            write_reg(REG_PAT_HIGH, words[3]);

            no_idle      = (phase_no == 3);
            phase_target = no_idle ? 150 : $urandom_range(80, 30);
            phase_count  = 0;
            while (phase_count < phase_target) begin
                if (eff >= 16) begin
                    line_len = $urandom_range(eff + 6, eff - 3);
                end else begin
                    line_len = $urandom_range(10, 0);
                end
                embed = (eff > 0) && ($urandom_range(1) == 1);
                if (embed && line_len < eff) begin
                    line_len = eff;
                end
                line_buf.delete();
                for (int i = 0; i < line_len; i++) begin
                    line_buf.push_back(pick_char());
                end
                if (embed) begin
                    pos = $urandom_range(line_len - eff, 0);
                    for (int j = 0; j < eff; j++) begin
                        line_buf[pos + j] = pat[j];
                    end
                    if ($urandom_range(4) == 0) begin
                        line_buf[pos + $urandom_range(eff - 1, 0)] ^= 8'h01;
                    end
                end
                ends_text = ($urandom_range(7) == 0);
                mark_last = ends_text && line_len > 0 && $urandom_range(1) == 1;
                for (int i = 0; i < line_len; i++) begin
                    queue_byte(line_buf[i], mark_last && i == line_len - 1);
                end
                if (ends_text && !mark_last) begin
                    queue_byte($urandom_range(1) ? NEWLINE_BYTE : pick_char(), 1'b1);
                    phase_count++;
                end else if (!ends_text) begin
                    queue_byte(NEWLINE_BYTE, 1'b0);
                    phase_count++;
                end
                phase_count += line_len;
                text_open    = !ends_text;
            end
            if (text_open && $urandom_range(9) < 7) begin
                queue_byte(8'($urandom_range(255)), 1'b1);
                phase_count++;
                text_open = 1'b0;
            end
            random_items += phase_count;
            phase_no++;
            wait_quiet();
            no_idle = 1'b0;
        end

        repeat (20) @(negedge aclk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cell.sv
hw/rtl/lpm_result_fifo.sv
hw/rtl/line_pattern_matcher.sv
hw/rtl/lpm_checker.sv
bench/line_pattern_matcher_tb.sv
